FILE: hdl/amd_pkg.sv
`default_nettype none

package amd_pkg;

    localparam int unsigned YEAR_W  = 16;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned DELTA_W = 32;
    localparam int unsigned QUOT_W  = 28;   // |delta| / 12 < 2^28
    localparam int unsigned SUM_W   = 30;   // year + quotient never wraps here

    localparam logic [31:0] RECIP3        = 32'hAAAA_AAAB;   // ceil(2^33 / 3)
    localparam logic [12:0] RECIP25       = 13'd5243;        // ceil(2^17 / 25)
    localparam logic [4:0]  DIV25         = 5'd25;
    localparam logic [3:0]  MONTHS        = 4'd12;
    localparam logic [3:0]  MONTH_OCT     = 4'd10;
    localparam logic [4:0]  FEB_LEAP_DAYS = 5'd29;
    localparam logic [4:0]  SWITCH_DAY    = 5'd15;
    localparam logic [4:0]  SWITCH_FIRST  = 5'd5;
    localparam logic [15:0] SWITCH_YEAR   = 16'd1582;
    localparam logic signed [SUM_W-1:0] YEAR_MAX = 30'sd32767;

    localparam logic [2:0] CFG_ADDR_MODE = 3'd0;
    localparam logic       CFG_MODE_RESET = 1'b1;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [DELTA_W-1:0] delta;
        logic               is_null;
    } in_item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [DAY_W-1:0]   start_last;
        logic [QUOT_W-1:0]  quot;
        logic               neg;
        logic [3:0]         mag_lo;
        logic               is_null;
    } quot_item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [DAY_W-1:0]   start_last;
        logic               ovf;
        logic               is_null;
    } shift_item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               is_null;
        logic               ovf;
    } out_item_t;

    // divisible by 100 <=> by 4 and by 25; by 400 <=> by 16 and by 25
    function automatic logic is_leap(input logic [YEAR_W-1:0] y, input logic julian_mode);
        logic [16:0] mag;
        logic [29:0] prod;
        logic [12:0] q25;
        logic [16:0] rem;
        logic        by4;
        logic        by16;
        logic        by25;
        mag  = y[15] ? (17'd0 - {1'b1, y}) : {1'b0, y};
        prod = {13'd0, mag} * {17'd0, RECIP25};
        q25  = prod[29:17];
        rem  = mag - 17'({4'd0, q25} * {12'd0, DIV25});
        by4  = (y[1:0] == 2'd0);
        by16 = (y[3:0] == 4'd0);
        by25 = (rem == 17'd0);
        if (julian_mode && ($signed(y) <= $signed(SWITCH_YEAR)))
            return by4;
        return by4 && (!by25 || by16);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] d;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            4'd2:                    d = leap ? FEB_LEAP_DAYS : 5'd28;
            default:                 d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/amd_quot.sv
`default_nettype none

module amd_quot (
    input  wire                   clk,
    input  wire                   load,
    input  wire                   calendar_mode,
    input  amd_pkg::in_item_t     item,
    output amd_pkg::quot_item_t   result_reg
);

    logic [amd_pkg::MONTH_W-1:0] month_c;
    logic [31:0]                 mag;
    logic [61:0]                 prod;
    amd_pkg::quot_item_t         result_next;

    always_comb
    begin
        if (item.month == 4'd0)
            month_c = 4'd1;
        else if (item.month > amd_pkg::MONTHS)
            month_c = amd_pkg::MONTHS;
        else
            month_c = item.month;

        mag  = item.delta[31] ? (32'd0 - item.delta) : item.delta;
        // |delta| / 12 = (|delta| >> 2) / 3 by reciprocal
        prod = {32'd0, mag[31:2]} * {30'd0, amd_pkg::RECIP3};

        result_next.year       = item.year;
        result_next.month      = month_c;
        result_next.day        = item.day;
        result_next.start_last = amd_pkg::month_len(month_c,
                                     amd_pkg::is_leap(item.year, calendar_mode));
        result_next.quot       = prod[60:33];
        result_next.neg        = item.delta[31];
        result_next.mag_lo     = mag[3:0];
        result_next.is_null    = item.is_null;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire

FILE: hdl/amd_shift.sv
`default_nettype none

module amd_shift (
    input  wire                   clk,
    input  wire                   load,
    input  amd_pkg::quot_item_t   item,
    output amd_pkg::shift_item_t  result_reg
);

    logic [3:0]                        q12_lo;
    logic [3:0]                        rem;
    logic signed [5:0]                 srem;
    logic signed [5:0]                 nm0;
    logic signed [5:0]                 nm1;
    logic signed [amd_pkg::SUM_W-1:0]  squot;
    logic signed [amd_pkg::SUM_W-1:0]  carry;
    logic signed [amd_pkg::SUM_W-1:0]  ny;
    amd_pkg::shift_item_t              result_next;

    always_comb
    begin
        // remainder is below 12, so four bits of |delta| - 12*q suffice
        q12_lo = {item.quot[0], 3'b000} + {item.quot[1:0], 2'b00};
        rem    = item.mag_lo - q12_lo;
        srem   = item.neg ? -$signed({2'b00, rem}) : $signed({2'b00, rem});
        squot  = item.neg ? -$signed({2'b00, item.quot}) : $signed({2'b00, item.quot});
        nm0    = $signed({2'b00, item.month}) + srem;

        if (nm0 > $signed({2'b00, amd_pkg::MONTHS}))
        begin
            nm1   = nm0 - $signed({2'b00, amd_pkg::MONTHS});
            carry = 30'sd1;
        end
        else if (nm0 < 6'sd1)
        begin
            nm1   = nm0 + $signed({2'b00, amd_pkg::MONTHS});
            carry = -30'sd1;
        end
        else
        begin
            nm1   = nm0;
            carry = 30'sd0;
        end

        ny = $signed({{(amd_pkg::SUM_W - amd_pkg::YEAR_W){item.year[15]}}, item.year})
             + squot + carry;

        result_next.year       = ny[amd_pkg::YEAR_W-1:0];
        result_next.month      = nm1[3:0];
        result_next.day        = item.day;
        result_next.start_last = item.start_last;
        result_next.ovf        = (ny > amd_pkg::YEAR_MAX) || (ny < -amd_pkg::YEAR_MAX);
        result_next.is_null    = item.is_null;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire

FILE: hdl/amd_day.sv
`default_nettype none

module amd_day (
    input  wire                   clk,
    input  wire                   load,
    input  wire                   calendar_mode,
    input  amd_pkg::shift_item_t  item,
    output amd_pkg::out_item_t    result_reg
);

    logic [amd_pkg::DAY_W-1:0] end_last;
    logic                      take_last;
    logic                      in_gap;
    amd_pkg::out_item_t        result_next;

    always_comb
    begin
        end_last  = amd_pkg::month_len(item.month,
                        amd_pkg::is_leap(item.year, calendar_mode));
        take_last = ((item.day != 5'd0) && (item.day == item.start_last))
                    || (item.day >= end_last);
        // days dropped at the gregorian switch
        in_gap    = (item.year == amd_pkg::SWITCH_YEAR) && (item.month == amd_pkg::MONTH_OCT)
                    && (item.day >= amd_pkg::SWITCH_FIRST) && (item.day < amd_pkg::SWITCH_DAY);

        result_next.year    = '0;
        result_next.month   = '0;
        result_next.day     = '0;
        result_next.is_null = 1'b0;
        result_next.ovf     = 1'b0;

        if (item.is_null)
            result_next.is_null = 1'b1;
        else if (item.ovf)
            result_next.ovf = 1'b1;
        else
        begin
            result_next.year  = item.year;
            result_next.month = item.month;
            if (take_last)
                result_next.day = end_last;
            else if (in_gap)
                result_next.day = amd_pkg::SWITCH_DAY;
            else
                result_next.day = item.day;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire

FILE: hdl/add_months_date.sv
`default_nettype none

// adds a signed month count to a calendar date with the end-of-month rule.
// one date is taken per clock while s_axis_tready is high, and each gives one result;
// the four register stages (input, divide by 12 and start month length,
// year/month shift, target month length and day) each advance independently,
// so a stalled output only holds back the stages behind it that are full.
// calendar_mode at address 0 selects julian leap years before 1583 (reset 1);
// write it only when no transaction is in flight.

module add_months_date (
    input  wire         clk,
    input  wire         rst_n,

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] start_year, [19:16] start_month, [24:20] start_day,
    // [56:25] month_delta, [63:57] zero
    input  wire  [63:0] s_axis_tdata,
    // [0] arg_is_null
    input  wire  [0:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [15:0] out_year, [19:16] out_month, [24:20] out_day, [31:25] zero
    output logic [31:0] m_axis_tdata,
    // [0] out_is_null, [1] overflow
    output logic [1:0]  m_axis_tuser,

    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 mode_reg;
    logic                 mode_sel;
    logic [3:0]           valid_reg;
    logic [3:0]           valid_next;
    logic [4:0]           advance;
    amd_pkg::in_item_t    in_item_next;
    amd_pkg::in_item_t    in_item_reg;
    amd_pkg::quot_item_t  quot_item;
    amd_pkg::shift_item_t shift_item;
    amd_pkg::out_item_t   out_item;

    // configuration port
    assign pready   = 1'b1;
    assign mode_sel = (paddr[2] == amd_pkg::CFG_ADDR_MODE[2]);
    assign prdata   = mode_sel ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= amd_pkg::CFG_MODE_RESET;
        else if (psel && penable && pwrite && pready && mode_sel)
            mode_reg <= pwdata[0];
    end

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        advance[4] = m_axis_tready;
        for (int i = 3; i >= 0; i--)
            advance[i] = !valid_reg[i] || advance[i+1];
        valid_next = {valid_reg[2:0], s_axis_tvalid};
    end

    assign s_axis_tready = advance[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int i = 0; i < 4; i++)
                if (advance[i])
                    valid_reg[i] <= valid_next[i];
        end
    end

    always_comb
    begin
        in_item_next.year    = s_axis_tdata[15:0];
        in_item_next.month   = s_axis_tdata[19:16];
        in_item_next.day     = s_axis_tdata[24:20];
        in_item_next.delta   = s_axis_tdata[56:25];
        in_item_next.is_null = s_axis_tuser[0];
    end

    always_ff @(posedge clk)
    begin
        if (advance[0])
            in_item_reg <= in_item_next;
    end

    amd_quot u_quot (
        .clk           (clk),
        .load          (advance[1]),
        .calendar_mode (mode_reg),
        .item          (in_item_reg),
        .result_reg    (quot_item)
    );

    amd_shift u_shift (
        .clk        (clk),
        .load       (advance[2]),
        .item       (quot_item),
        .result_reg (shift_item)
    );

    amd_day u_day (
        .clk           (clk),
        .load          (advance[3]),
        .calendar_mode (mode_reg),
        .item          (shift_item),
        .result_reg    (out_item)
    );

    assign m_axis_tvalid = valid_reg[3];
    assign m_axis_tdata  = {7'd0, out_item.day, out_item.month, out_item.year};
    assign m_axis_tuser  = {out_item.ovf, out_item.is_null};

endmodule

`default_nettype wire
